>>> src/asl_pkg.sv
// Shared constants and types for the aspect preserving size limiter.
package asl_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int OUT_W        = 32;
  localparam int NUM_LANES    = 8;
  localparam int NUM_MIN_STG  = 4;
  localparam int IDX_W        = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_BOTH   = 3'd0,
    REG_MAX_WIDTH  = 3'd1,
    REG_MAX_HEIGHT = 3'd2,
    REG_MIN_BOTH   = 3'd3,
    REG_MIN_WIDTH  = 3'd4,
    REG_MIN_HEIGHT = 3'd5
  } reg_idx_t;

endpackage

>>> src/aspect_preserving_size_limiter.sv
// Top level: pipelined aspect preserving dimension clamp with output skid stage.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, source_width/height  | input transaction
//  out     | out_valid, out_stall, target_*, unchanged | output transaction
//  cfg     | cfg_write, cfg_index, cfg_data           | register write
//
// One transaction per cycle while in_stall is low. The pipe runs through an input register,
// a product register, the restoring dividers with one quotient bit per stage, one register
// stage per clamp and the output register.
// Reset clears all valid bits and the six limit registers.
// A stall at the output fills the skid stage when a valid result arrives; in_stall then holds the whole pipe.
module aspect_preserving_size_limiter #(
  parameter int DIM_BITS = asl_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [asl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [DIM_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DIM_BITS-1:0]           source_width,
  input  logic [DIM_BITS-1:0]           source_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [asl_pkg::OUT_W-1:0]     target_width,
  output logic [asl_pkg::OUT_W-1:0]     target_height,
  output logic                          unchanged
);

  localparam int PW = 2 * DIM_BITS;
  localparam int NX = 2 * DIM_BITS + 1;
  localparam int RW = DIM_BITS + 1;
  localparam int OW = asl_pkg::OUT_W;
  localparam int NL = asl_pkg::NUM_LANES;
  localparam int NM = asl_pkg::NUM_MIN_STG;

  logic [DIM_BITS-1:0] max_both, max_width, max_height;
  logic [DIM_BITS-1:0] min_both, min_width, min_height;
  logic [DIM_BITS-1:0] lim [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_both   <= '0;
      max_width  <= '0;
      max_height <= '0;
      min_both   <= '0;
      min_width  <= '0;
      min_height <= '0;
    end else if (cfg_write) begin
      unique case (asl_pkg::reg_idx_t'(cfg_index))
        asl_pkg::REG_MAX_BOTH:   max_both   <= cfg_data;
        asl_pkg::REG_MAX_WIDTH:  max_width  <= cfg_data;
        asl_pkg::REG_MAX_HEIGHT: max_height <= cfg_data;
        asl_pkg::REG_MIN_BOTH:   min_both   <= cfg_data;
        asl_pkg::REG_MIN_WIDTH:  min_width  <= cfg_data;
        asl_pkg::REG_MIN_HEIGHT: min_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim[0] = min_both;
  assign lim[1] = min_both;
  assign lim[2] = min_width;
  assign lim[3] = min_height;
  assign lim[4] = max_both;
  assign lim[5] = max_both;
  assign lim[6] = max_width;
  assign lim[7] = max_height;

  logic skid_v;
  logic en;
  assign en       = !skid_v;
  assign in_stall = skid_v;

  // input register
  logic                v0;
  logic [DIM_BITS-1:0] s0_w, s0_h;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_w <= source_width;
      s0_h <= source_height;
    end
  end

  // products limit * numerator
  logic                v1;
  logic [DIM_BITS-1:0] s1_w, s1_h;
  logic [PW-1:0]       prod [NL];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_w <= s0_w;
      s1_h <= s0_h;
      for (int l = 0; l < NL; l++) begin
        prod[l] <= PW'(lim[l]) * PW'(((l % 2) == 0) ? s0_h : s0_w);
      end
    end
  end

  // restoring divider pipeline, one quotient bit per stage
  logic                dv [NX+1];
  logic [DIM_BITS-1:0] dw [NX+1];
  logic [DIM_BITS-1:0] dh [NX+1];
  logic [NX-1:0]       dx [NX+1][NL];
  logic [RW-1:0]       dr [NX+1][NL];
  logic [NX-1:0]       dq [NX+1][NL];

  assign dv[0] = v1;
  assign dw[0] = s1_w;
  assign dh[0] = s1_h;
  for (genvar l = 0; l < NL; l++) begin : g_init
    assign dx[0][l] = {prod[l], 1'b0} +
                      NX'(((l % 2) == 0) ? s1_w : s1_h);
    assign dr[0][l] = '0;
    assign dq[0][l] = '0;
  end

  for (genvar j = 0; j < NX; j++) begin : g_div
    logic                v_r;
    logic [DIM_BITS-1:0] w_r, h_r;
    logic [NX-1:0]       x_r [NL];
    logic [RW-1:0]       r_r [NL];
    logic [NX-1:0]       q_r [NL];
    logic [RW-1:0]       r_next [NL];
    logic [NX-1:0]       q_next [NL];

    always_comb begin
      logic [RW:0]   trial;
      logic [RW-1:0] div;
      for (int l = 0; l < NL; l++) begin
        div       = {(((l % 2) == 0) ? dw[j] : dh[j]), 1'b0};
        trial     = {dr[j][l], dx[j][l][NX-1-j]};
        q_next[l] = dq[j][l];
        if (trial >= {1'b0, div}) begin
          r_next[l]         = RW'(trial - {1'b0, div});
          q_next[l][NX-1-j] = 1'b1;
        end else begin
          r_next[l] = RW'(trial);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= dv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        w_r <= dw[j];
        h_r <= dh[j];
        for (int l = 0; l < NL; l++) begin
          x_r[l] <= dx[j][l];
          r_r[l] <= r_next[l];
          q_r[l] <= q_next[l];
        end
      end
    end

    assign dv[j+1] = v_r;
    assign dw[j+1] = w_r;
    assign dh[j+1] = h_r;
    for (genvar l = 0; l < NL; l++) begin : g_con
      assign dx[j+1][l] = x_r[l];
      assign dr[j+1][l] = r_r[l];
      assign dq[j+1][l] = q_r[l];
    end
  end

  // clamp chain, one stage per limit
  logic                cv [NL+1];
  logic [DIM_BITS-1:0] csw [NL+1];
  logic [DIM_BITS-1:0] csh [NL+1];
  logic [OW-1:0]       cw [NL+1];
  logic [OW-1:0]       ch [NL+1];
  logic [OW-1:0]       cres [NL+1][NL];

  assign cv[0]  = dv[NX];
  assign csw[0] = dw[NX];
  assign csh[0] = dh[NX];
  assign cw[0]  = OW'(dw[NX]);
  assign ch[0]  = OW'(dh[NX]);
  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [NX+OW-1:0] qe;
    logic             zero_den;
    assign qe       = {{OW{1'b0}}, dq[NX][l]};
    assign zero_den = (((l % 2) == 0) ? dw[NX] : dh[NX]) == '0;
    assign cres[0][l] = (zero_den || ((qe >> OW) != '0)) ? '1 : qe[OW-1:0];
  end

  for (genvar k = 0; k < NL; k++) begin : g_clamp
    logic                v_r;
    logic [DIM_BITS-1:0] sw_r, sh_r;
    logic [OW-1:0]       w_r, h_r;
    logic [OW-1:0]       res_r [NL];
    logic [OW-1:0]       l_ext, cur;
    logic                hit;
    logic [OW-1:0]       w_next, h_next;

    assign l_ext = OW'(lim[k]);
    assign cur   = ((k % 2) == 0) ? cw[k] : ch[k];
    assign hit   = (lim[k] != '0) && ((k < NM) ? (cur < l_ext) : (cur > l_ext));

    always_comb begin
      w_next = cw[k];
      h_next = ch[k];
      if (hit) begin
        if ((k % 2) == 0) begin
          w_next = l_ext;
          h_next = cres[k][k];
        end else begin
          h_next = l_ext;
          w_next = cres[k][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= cv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sw_r  <= csw[k];
        sh_r  <= csh[k];
        w_r   <= w_next;
        h_r   <= h_next;
        res_r <= cres[k];
      end
    end

    assign cv[k+1]   = v_r;
    assign csw[k+1]  = sw_r;
    assign csh[k+1]  = sh_r;
    assign cw[k+1]   = w_r;
    assign ch[k+1]   = h_r;
    assign cres[k+1] = res_r;
  end

  // output register and skid stage
  logic          p_un;
  logic [OW-1:0] skid_w, skid_h;
  logic          skid_un;
  logic          take;

  assign p_un = (cw[NL] == OW'(csw[NL])) && (ch[NL] == OW'(csh[NL]));
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid <= skid_v || cv[NL];
      skid_v    <= 1'b0;
    end else if (!skid_v && cv[NL]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_v) begin
        target_width  <= skid_w;
        target_height <= skid_h;
        unchanged     <= skid_un;
      end else begin
        target_width  <= cw[NL];
        target_height <= ch[NL];
        unchanged     <= p_un;
      end
    end else if (!skid_v) begin
      skid_w  <= cw[NL];
      skid_h  <= ch[NL];
      skid_un <= p_un;
    end
  end

endmodule

>>> src/asl_checker.sv
// Port-level checker for the aspect preserving size limiter, with its bind.
module asl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [asl_pkg::OUT_W-1:0] target_width
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("valid or stall set after reset");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held with no pending output");

  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("skid stage not drained after output transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(target_width)))
    else $error("stalled output changed");

endmodule

bind aspect_preserving_size_limiter asl_checker u_asl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .target_width (target_width)
);

>>> sim/tb.sv
// Testbench for the aspect preserving size limiter: random and directed dimension checks.
`timescale 1ns / 1ps

module tb;

  localparam int DW      = 16;
  localparam int LATENCY = 2 * DW + 12;
  localparam int LIMIT   = 2000000;

  typedef struct packed {
    logic [DW-1:0] w;
    logic [DW-1:0] h;
  } dims_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] h;
    logic        same;
  } target_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [asl_pkg::IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DW-1:0] source_width = '0;
  logic [DW-1:0] source_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] target_width;
  logic [31:0] target_height;
  logic unchanged;

  dims_t   pending_dims[$];
  target_t expected_targets[$];
  int      errors = 0;
  int      cycles = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  bit      driving = 0;
  logic    in_stall_q = 1'b1;
  logic    out_valid_q = 1'b0;
  logic [DW-1:0] lim_max_both, lim_max_w, lim_max_h, lim_min_both, lim_min_w, lim_min_h;

  always #2ns clk = ~clk;

  aspect_preserving_size_limiter #(.DIM_BITS(DW)) i_dut (.*);

  function automatic logic [63:0] rescale(logic [63:0] lim, logic [63:0] num,
                                          logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return 64'hFFFF_FFFF;
    q = (2 * lim * num + den) / (2 * den);
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic target_t clamp_dims(dims_t s);
    logic [63:0] w, h;
    target_t t;
    w = s.w;
    h = s.h;
    if (lim_min_both != 0 && w < lim_min_both) begin
      w = lim_min_both; h = rescale(w, s.h, s.w);
    end
    if (lim_min_both != 0 && h < lim_min_both) begin
      h = lim_min_both; w = rescale(h, s.w, s.h);
    end
    if (lim_min_w != 0 && w < lim_min_w) begin
      w = lim_min_w; h = rescale(w, s.h, s.w);
    end
    if (lim_min_h != 0 && h < lim_min_h) begin
      h = lim_min_h; w = rescale(h, s.w, s.h);
    end
    if (lim_max_both != 0 && w > lim_max_both) begin
      w = lim_max_both; h = rescale(w, s.h, s.w);
    end
    if (lim_max_both != 0 && h > lim_max_both) begin
      h = lim_max_both; w = rescale(h, s.w, s.h);
    end
    if (lim_max_w != 0 && w > lim_max_w) begin
      w = lim_max_w; h = rescale(w, s.h, s.w);
    end
    if (lim_max_h != 0 && h > lim_max_h) begin
      h = lim_max_h; w = rescale(h, s.w, s.h);
    end
    t.w = w[31:0];
    t.h = h[31:0];
    t.same = (w == s.w && h == s.h);
    return t;
  endfunction

  task automatic write_limit(asl_pkg::reg_idx_t idx, logic [DW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      asl_pkg::REG_MAX_BOTH:   lim_max_both = val;
      asl_pkg::REG_MAX_WIDTH:  lim_max_w = val;
      asl_pkg::REG_MAX_HEIGHT: lim_max_h = val;
      asl_pkg::REG_MIN_BOTH:   lim_min_both = val;
      asl_pkg::REG_MIN_WIDTH:  lim_min_w = val;
      asl_pkg::REG_MIN_HEIGHT: lim_min_h = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [DW-1:0] mxb, logic [DW-1:0] mxw, logic [DW-1:0] mxh,
                            logic [DW-1:0] mnb, logic [DW-1:0] mnw, logic [DW-1:0] mnh);
    write_limit(asl_pkg::REG_MAX_BOTH, mxb);
    write_limit(asl_pkg::REG_MAX_WIDTH, mxw);
    write_limit(asl_pkg::REG_MAX_HEIGHT, mxh);
    write_limit(asl_pkg::REG_MIN_BOTH, mnb);
    write_limit(asl_pkg::REG_MIN_WIDTH, mnw);
    write_limit(asl_pkg::REG_MIN_HEIGHT, mnh);
  endtask

  function automatic logic [DW-1:0] rand_dim();
    case ($urandom_range(0, 3))
      0: return DW'($urandom_range(0, 64));
      1: return DW'($urandom_range(0, 2000));
      2: return DW'($urandom_range(65000, 65535));
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_limit();
    return ($urandom_range(0, 2) == 0) ? '0 : rand_dim();
  endfunction

  task automatic send(logic [DW-1:0] w, logic [DW-1:0] h);
    dims_t d;
    d.w = w;
    d.h = h;
    pending_dims.push_back(d);
  endtask

  task automatic drain();
    wait (pending_dims.size() == 0 && !driving && expected_targets.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // driver: present transactions, idle a drawn number of cycles between them
  always @(negedge clk) begin
    dims_t d;
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        driving = 0;
        in_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (!(in_valid && in_stall_q)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_dims.size() > 0) begin
          d = pending_dims.pop_front();
          expected_targets.push_back(clamp_dims(d));
          source_width  <= d.w;
          source_height <= d.h;
          in_valid <= 1'b1;
          driving = 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
        if (out_valid_q && $urandom_range(0, 2) == 0) out_gap = $urandom_range(0, 14);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    target_t exp_t;
    out_valid_q <= out_valid && !out_stall;
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_targets.size() == 0) begin
        $display("%0t unexpected transaction w=%0d h=%0d", $time, target_width,
                 target_height);
        errors++;
      end else begin
        exp_t = expected_targets.pop_front();
        if (target_width !== exp_t.w) begin
          $display("%0t target_width expected %0d actual %0d", $time, exp_t.w, target_width);
          errors++;
        end
        if (target_height !== exp_t.h) begin
          $display("%0t target_height expected %0d actual %0d", $time, exp_t.h,
                   target_height);
          errors++;
        end
        if (unchanged !== exp_t.same) begin
          $display("%0t unchanged expected %0d actual %0d", $time, exp_t.same, unchanged);
          errors++;
        end
      end
    end
  end

  initial begin
    {lim_max_both, lim_max_w, lim_max_h, lim_min_both, lim_min_w, lim_min_h} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(16'd1920, 16'd1080);
    send(16'hFFFF, 16'hFFFF);
    send(16'd1, 16'd1);
    send(16'd0, 16'd0);
    drain();
    set_limits(16'd1000, 16'd800, 16'd600, 16'd100, 16'd200, 16'd150);
    send(16'd1920, 16'd1080);
    send(16'd50, 16'd20);
    send(16'd20, 16'd50);
    send(16'd0, 16'd40);
    send(16'd40, 16'd0);
    send(16'hFFFF, 16'd1);
    send(16'd1, 16'hFFFF);
    send(16'd3, 16'd2);
    drain();
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'd1, 16'hFFFF);
    send(16'hFFFF, 16'h8000);
    send(16'd0, 16'd5);
    drain();
    set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send(16'd7, 16'd3);
    send(16'hFFFF, 16'hAAAA);
    drain();
    // reach past the last index, which the block must ignore
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data  <= 16'h1234;
    @(negedge clk);
    cfg_write <= 1'b0;
    send(16'd300, 16'd200);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7)
        set_limits('0, '0, '0, '0, '0, '0);
      else
        set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit(), rand_limit(),
                   rand_limit());
      for (int n = 0; n < 118; n++) send(rand_dim(), rand_dim());
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> aspect_preserving_size_limiter.f
src/asl_pkg.sv
src/aspect_preserving_size_limiter.sv
src/asl_checker.sv
sim/tb.sv
